[rtl/a2q_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package a2q_pkg;

	// angle turn constants in 1/256 degree units
	localparam logic [20:0] TURN_FULL    = 21'd184320;
	localparam logic [20:0] TURN_BIAS    = 21'd552960;
	localparam logic [19:0] TURN_HALF    = 20'd92160;
	localparam logic [19:0] TURN_QUARTER = 20'd46080;
	localparam logic [19:0] TURN_3Q      = 20'd138240;

	// floor(pi * 2^62 / 92160): radians of the half angle per angle unit, Q62
	localparam logic [47:0] RAD_K = 48'd157205283378409;

	localparam logic signed [32:0] CORDIC_KINV = 33'sd652032874;

	localparam int SQRT_STEPS = 32;

	localparam logic [31:0] ATAN_HEAD [11] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF
	};

	typedef struct packed {
		logic signed [19:0] angle_deg;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] conj_x;
		logic signed [15:0] conj_y;
		logic signed [15:0] conj_z;
		logic               zero_axis;
	} out_beat_t;

	// state carried along the rotator / square root chain
	typedef struct packed {
		logic               flip;
		logic               zero;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [32:0] cx;
		logic signed [32:0] cy;
		logic signed [32:0] cz;
		logic [33:0]        rem;
		logic [31:0]        root;
		logic [31:0]        nbits;
	} cell_t;

	function automatic logic signed [32:0] atan_q30(input int i);
		if (i < 11) begin
			return 33'(ATAN_HEAD[i[3:0]]);
		end else if (i <= 30) begin
			return (33'sd1 <<< (30 - i)) - 33'sd1;
		end else begin
			return 33'sd0;
		end
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767) begin
			return 16'sh7fff;
		end else if (v < -40'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

`default_nettype wire

[rtl/a2q_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface a2q_in_if;
	logic               valid;
	logic               ready;
	a2q_pkg::in_beat_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface a2q_out_if;
	logic               valid;
	logic               ready;
	a2q_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/a2q_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module a2q_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              beat_valid,
	input  wire a2q_pkg::in_beat_t beat,
	output logic                   succ_valid,
	output a2q_pkg::cell_t         succ
);
	import a2q_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [20:0]        t_s1;
	logic [17:0]        r_s2;
	logic [15:0]        mag_s3;
	logic               neg_s3, neg_s4;
	logic               flip_s3, flip_s4;
	logic [39:0]        pl_s4, ph_s4;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic [31:0]        n2_s2, n2_s3, n2_s4;
	logic               zero_s2, zero_s3, zero_s4;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic signed [15:0] ax_s2, ay_s2, az_s2;
	logic signed [15:0] ax_s3, ay_s3, az_s3;
	logic signed [15:0] ax_s4, ay_s4, az_s4;

	logic signed [21:0] tsum;
	logic signed [31:0] px, py, pz;
	logic [20:0]        tsub;
	logic [31:0]        n2;
	logic signed [19:0] rs, rf;
	logic [63:0]        zs;
	logic signed [32:0] zm;

	always_comb begin
		tsum = 22'(beat.angle_deg) + 22'sd552960;
		px = beat.axis_x * beat.axis_x;
		py = beat.axis_y * beat.axis_y;
		pz = beat.axis_z * beat.axis_z;

		// biased angle stays below six turns, so one parallel compare picks the multiple
		if (t_s1 >= 21'(5 * TURN_FULL)) begin
			tsub = 21'(5 * TURN_FULL);
		end else if (t_s1 >= 21'(4 * TURN_FULL)) begin
			tsub = 21'(4 * TURN_FULL);
		end else if (t_s1 >= 21'(3 * TURN_FULL)) begin
			tsub = 21'(3 * TURN_FULL);
		end else if (t_s1 >= 21'(2 * TURN_FULL)) begin
			tsub = 21'(2 * TURN_FULL);
		end else if (t_s1 >= TURN_FULL) begin
			tsub = TURN_FULL;
		end else begin
			tsub = 21'd0;
		end
		n2 = 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);

		// fold into a quarter turn either side of zero
		rs = signed'(20'(r_s2));
		if (r_s2 <= 18'(TURN_QUARTER)) begin
			rf = rs;
		end else if (r_s2 < 18'(TURN_3Q)) begin
			rf = rs - signed'(TURN_HALF);
		end else begin
			rf = rs - signed'(20'(TURN_FULL));
		end

		zs = {ph_s4, 24'd0} + 64'(pl_s4) + 64'h0000_0000_8000_0000;
		zm = signed'({1'b0, zs[63:32]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			succ_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= beat_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			succ_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= tsum[20:0];
			sqx_s1 <= px[30:0];
			sqy_s1 <= py[30:0];
			sqz_s1 <= pz[30:0];
			ax_s1 <= beat.axis_x;
			ay_s1 <= beat.axis_y;
			az_s1 <= beat.axis_z;

			r_s2 <= 18'(t_s1 - tsub);
			n2_s2 <= n2;
			zero_s2 <= (n2 == 32'd0);
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			az_s2 <= az_s1;

			mag_s3 <= rf[19] ? 16'(-rf) : 16'(rf);
			neg_s3 <= rf[19];
			flip_s3 <= (r_s2 > 18'(TURN_QUARTER)) && (r_s2 < 18'(TURN_3Q));
			n2_s3 <= n2_s2;
			zero_s3 <= zero_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;

			pl_s4 <= mag_s3 * RAD_K[23:0];
			ph_s4 <= mag_s3 * RAD_K[47:24];
			neg_s4 <= neg_s3;
			flip_s4 <= flip_s3;
			n2_s4 <= n2_s3;
			zero_s4 <= zero_s3;
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
			az_s4 <= az_s3;

			succ.flip <= flip_s4;
			succ.zero <= zero_s4;
			succ.ax <= ax_s4;
			succ.ay <= ay_s4;
			succ.az <= az_s4;
			succ.cx <= CORDIC_KINV;
			succ.cy <= 33'sd0;
			succ.cz <= neg_s4 ? -zm : zm;
			succ.rem <= 34'd0;
			succ.root <= 32'd0;
			succ.nbits <= n2_s4;
		end
	end

endmodule

`default_nettype wire

[rtl/a2q_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module a2q_cell #(
	parameter int IDX     = 0,
	parameter int CSTAGES = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           prev_valid,
	input  wire a2q_pkg::cell_t prev,
	output logic                succ_valid,
	output a2q_pkg::cell_t      succ
);
	import a2q_pkg::*;

	cell_t              nxt;
	logic signed [32:0] dx, dy, at;
	logic [33:0]        r2, trial;
	logic               ge;

	always_comb begin
		nxt = prev;
		dx = prev.cy >>> IDX;
		dy = prev.cx >>> IDX;
		at = atan_q30(IDX);
		// cells past the rotator length only run the root digit
		if (IDX < CSTAGES) begin
			if (!prev.cz[32]) begin
				nxt.cx = prev.cx - dx;
				nxt.cy = prev.cy + dy;
				nxt.cz = prev.cz - at;
			end else begin
				nxt.cx = prev.cx + dx;
				nxt.cy = prev.cy - dy;
				nxt.cz = prev.cz + at;
			end
		end
		// one root bit per cell, two radicand bits shifted in
		r2 = {prev.rem[31:0], prev.nbits[31:30]};
		trial = {prev.root, 2'b01};
		ge = (r2 >= trial);
		nxt.rem = ge ? r2 - trial : r2;
		nxt.root = {prev.root[30:0], ge};
		nxt.nbits = {prev.nbits[29:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			succ_valid <= 1'b0;
		end else if (en) begin
			succ_valid <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			succ <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/a2q_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module a2q_div_cell #(
	parameter int BIT  = 0,
	parameter int W    = 52,
	parameter int DENW = 32,
	parameter int QW   = 17
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [DENW-1:0] den,
	input  wire logic [W-1:0]    prev_rem,
	input  wire logic [QW-1:0]   prev_quo,
	output logic [W-1:0]         succ_rem,
	output logic [QW-1:0]        succ_quo
);

	logic [W-1:0] sh;
	logic         ge;

	always_comb begin
		sh = W'(den) << BIT;
		ge = (prev_rem >= sh);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			succ_rem <= ge ? prev_rem - sh : prev_rem;
			succ_quo <= prev_quo | (QW'(ge) << BIT);
		end
	end

endmodule

`default_nettype wire

[rtl/axis_angle_to_quaternion.sv]
`timescale 1ns / 1ps
`default_nettype none

// Axis-angle to unit quaternion converter.
// rot (sink): angle in Q12.8 degrees and a signed integer axis of any length.
// quat (source): quaternion x, y, z, w in Q1.15 (OUT_FRAC_BITS fraction bits),
// the negated vector part, and a flag for a zero-length axis, in which case
// the identity comes out.
// Both channels move a beat when valid and ready are high at a clock edge.
// Throughput is one beat per cycle unless the output stalls. Stages in order:
// five front stages for angle reduction and radian scaling, a row of 32 cells
// that each do one bit of the axis-norm square root, the first CORDIC_STAGES of
// them also a rotator step, two stages for the products, one cell per quotient
// bit for the three divides, and the output register.
// Reset clears all valid bits; no item is in flight afterwards.
// While the receiver stalls, the result waits in the output register and the
// pipeline keeps taking beats until an item reaches its last stage; then
// ready drops until the output is taken.
module axis_angle_to_quaternion #(
	parameter int CORDIC_STAGES = 16,
	parameter int OUT_FRAC_BITS = 15
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	a2q_in_if.sink     rot,
	a2q_out_if.source  quat
);
	import a2q_pkg::*;

	localparam int SHN  = (OUT_FRAC_BITS >= 14) ? OUT_FRAC_BITS - 14 : 0;
	localparam int SHD  = (OUT_FRAC_BITS >= 14) ? 0 : 14 - OUT_FRAC_BITS;
	localparam int NUMW = 48 + SHN;
	localparam int DENW = 32 + SHD;
	localparam int DVW  = NUMW + SHD + 4;
	localparam int QW   = OUT_FRAC_BITS + 2;
	localparam int WSH  = 30 - OUT_FRAC_BITS;
	localparam logic signed [33:0] WRND =
		(WSH > 0) ? (34'sd1 <<< ((WSH > 0) ? WSH - 1 : 0)) : 34'sd0;
	localparam logic signed [15:0] W_ONE = sat16(40'sd1 <<< OUT_FRAC_BITS);

	logic en;

	cell_t chain [SQRT_STEPS+1];
	logic  chain_v [SQRT_STEPS+1];

	// global advance: blocked only when a finished item cannot leave
	logic      out_valid_q;
	out_beat_t out_q;
	logic      v_last;

	assign en = !v_last || !out_valid_q || quat.ready;
	assign rot.ready = en;
	assign quat.valid = out_valid_q;
	assign quat.data = out_q;

	a2q_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.beat_valid (rot.valid),
		.beat       (rot.data),
		.succ_valid (chain_v[0]),
		.succ       (chain[0])
	);

	for (genvar c = 0; c < SQRT_STEPS; c++) begin : g_cell
		a2q_cell #(
			.IDX     (c),
			.CSTAGES (CORDIC_STAGES)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.prev_valid (chain_v[c]),
			.prev       (chain[c]),
			.succ_valid (chain_v[c+1]),
			.succ       (chain[c+1])
		);
	end

	// products of axis magnitude and sine, plus the cosine output
	cell_t              tl;
	logic signed [32:0] cs, sn;
	logic signed [33:0] wsum, wsh;
	logic [31:0]        ms;
	logic signed [15:0] av [3];
	logic [15:0]        ma [3];
	logic [47:0]        num [3];
	logic [2:0]         negv;
	logic [DENW-1:0]    den;

	logic               v_s1, v_s2;
	logic [47:0]        num_s1 [3];
	logic [2:0]         neg_s1, neg_s2;
	logic signed [15:0] w_s1, w_s2;
	logic [31:0]        nq_s1;
	logic               zero_s1, zero_s2;
	logic [DVW-1:0]     rem_s2 [3];
	logic [DENW-1:0]    den_s2;

	always_comb begin
		tl = chain[SQRT_STEPS];
		cs = tl.flip ? -tl.cx : tl.cx;
		sn = tl.flip ? -tl.cy : tl.cy;
		wsum = 34'(cs) + WRND;
		wsh = wsum >>> WSH;
		ms = sn[32] ? 32'(-sn) : sn[31:0];
		av[0] = tl.ax;
		av[1] = tl.ay;
		av[2] = tl.az;
		for (int i = 0; i < 3; i++) begin
			ma[i] = av[i][15] ? 16'(-av[i]) : 16'(av[i]);
			num[i] = ma[i] * ms;
			negv[i] = av[i][15] ^ sn[32];
		end
		den = DENW'(nq_s1) << SHD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= chain_v[SQRT_STEPS];
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_s1[i] <= num[i];
				// dividend carries the half-divisor for round half up
				rem_s2[i] <= (DVW'(num_s1[i]) << SHN) + DVW'(den >> 1);
			end
			neg_s1 <= negv;
			w_s1 <= sat16(40'(wsh));
			nq_s1 <= tl.root;
			zero_s1 <= tl.zero;

			neg_s2 <= neg_s1;
			w_s2 <= w_s1;
			zero_s2 <= zero_s1;
			den_s2 <= den;
		end
	end

	// restoring divide, one quotient bit per cell, msb first
	logic [DVW-1:0]     drem [3][QW+1];
	logic [QW-1:0]      dquo [3][QW+1];
	logic [DENW-1:0]    dden [QW+1];
	logic               dv [QW+1];
	logic [2:0]         dneg [QW+1];
	logic signed [15:0] dw [QW+1];
	logic               dzero [QW+1];

	for (genvar i = 0; i < 3; i++) begin : g_lane_in
		assign drem[i][0] = rem_s2[i];
		assign dquo[i][0] = '0;
	end
	assign dden[0] = den_s2;
	assign dv[0] = v_s2;
	assign dneg[0] = neg_s2;
	assign dw[0] = w_s2;
	assign dzero[0] = zero_s2;

	for (genvar j = 0; j < QW; j++) begin : g_div
		for (genvar i = 0; i < 3; i++) begin : g_lane
			a2q_div_cell #(
				.BIT  (QW - 1 - j),
				.W    (DVW),
				.DENW (DENW),
				.QW   (QW)
			) u_div (
				.clk      (clk),
				.en       (en),
				.den      (dden[j]),
				.prev_rem (drem[i][j]),
				.prev_quo (dquo[i][j]),
				.succ_rem (drem[i][j+1]),
				.succ_quo (dquo[i][j+1])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[j+1] <= 1'b0;
			end else if (en) begin
				dv[j+1] <= dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dden[j+1] <= dden[j];
				dneg[j+1] <= dneg[j];
				dw[j+1] <= dw[j];
				dzero[j+1] <= dzero[j];
			end
		end
	end

	assign v_last = dv[QW];

	logic [16:0]        qc [3];
	logic signed [39:0] sv [3];
	logic signed [15:0] qo [3];
	logic signed [15:0] co [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (32'(dquo[i][QW]) > 32'd65536) ? 17'd65536 : 17'(dquo[i][QW]);
			sv[i] = dneg[QW][i] ? -signed'(40'(qc[i])) : signed'(40'(qc[i]));
			qo[i] = sat16(sv[i]);
			co[i] = sat16(-40'(qo[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && v_last) begin
			out_valid_q <= 1'b1;
		end else if (quat.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_last) begin
			if (dzero[QW]) begin
				out_q.quat_x <= 16'sd0;
				out_q.quat_y <= 16'sd0;
				out_q.quat_z <= 16'sd0;
				out_q.quat_w <= W_ONE;
				out_q.conj_x <= 16'sd0;
				out_q.conj_y <= 16'sd0;
				out_q.conj_z <= 16'sd0;
				out_q.zero_axis <= 1'b1;
			end else begin
				out_q.quat_x <= qo[0];
				out_q.quat_y <= qo[1];
				out_q.quat_z <= qo[2];
				out_q.quat_w <= dw[QW];
				out_q.conj_x <= co[0];
				out_q.conj_y <= co[1];
				out_q.conj_z <= co[2];
				out_q.zero_axis <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import a2q_pkg::*;

	localparam int HALF_TURN    = 92160;
	localparam int FULL_TURN    = 184320;
	localparam int QUARTER_TURN = 46080;
	localparam longint unsigned RAD_PER_UNIT = 64'd157205283378409;
	localparam longint KINV = 64'sd652032874;
	localparam int STAGES = 16;
	localparam int FRAC = 15;
	localparam int LATENCY = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	a2q_in_if  rot ();
	a2q_out_if quat ();

	axis_angle_to_quaternion u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rot   (rot),
		.quat  (quat)
	);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	out_beat_t quat_expected[$];
	int        mismatches = 0;
	bit        stimulus_done = 1'b0;
	bit        hold_off = 1'b0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_entry(int i);
		if (i < 11) return longint'(ATAN_HEAD[i]);
		if (i <= 30) return (64'sd1 << (30 - i)) - 1;
		return 0;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint axis_times_sine(longint a, longint s, longint unsigned nq);
		bit neg = (a < 0) != (s < 0);
		longint unsigned ma = (a < 0) ? -a : a;
		longint unsigned ms = (s < 0) ? -s : s;
		longint unsigned num = (ma * ms) << (FRAC - 14);
		longint unsigned q = (num + nq / 2) / nq;
		if (q > 65536) q = 65536;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic out_beat_t rotation_quat(in_beat_t b);
		out_beat_t o;
		longint r, x, y, z, dx, dy, cs, sn, ax, ay, az;
		longint unsigned mag, n2, nq;
		bit flip = 1'b0;
		ax = b.axis_x; ay = b.axis_y; az = b.axis_z;
		r = longint'(b.angle_deg) % FULL_TURN;
		if (r < 0) r += FULL_TURN;
		if (r > HALF_TURN) r -= FULL_TURN;
		if (r > QUARTER_TURN) begin
			r -= HALF_TURN; flip = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r += HALF_TURN; flip = 1'b1;
		end
		mag = (r < 0) ? -r : r;
		mag = (mag * RAD_PER_UNIT + (64'd1 << 31)) >> 32;
		z = (r < 0) ? -longint'(mag) : longint'(mag);
		x = KINV; y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = shr_floor(y, i); dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
		o.quat_w = clamp16(shr_floor(cs + (64'sd1 << (29 - FRAC)), 30 - FRAC));
		n2 = ax * ax + ay * ay + az * az;
		if (n2 == 0) begin
			o = '0;
			o.quat_w = clamp16(64'sd1 << FRAC);
			o.zero_axis = 1'b1;
			return o;
		end
		nq = root64(n2 << 32);
		o.quat_x = clamp16(axis_times_sine(ax, sn, nq));
		o.quat_y = clamp16(axis_times_sine(ay, sn, nq));
		o.quat_z = clamp16(axis_times_sine(az, sn, nq));
		o.conj_x = clamp16(-longint'(o.quat_x));
		o.conj_y = clamp16(-longint'(o.quat_y));
		o.conj_z = clamp16(-longint'(o.quat_z));
		o.zero_axis = 1'b0;
		return o;
	endfunction

	function automatic int gap_len();
		int p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// directed rows; known marks rows whose result is typed in
	typedef struct {
		in_beat_t  beat;
		bit        known;
		out_beat_t result;
	} rot_row_t;

	localparam out_beat_t IDENTITY = '{16'sd0, 16'sd0, 16'sd0, 16'sh7fff,
		16'sd0, 16'sd0, 16'sd0, 1'b1};

	rot_row_t rows[] = '{
		'{'{20'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, IDENTITY},
		'{'{20'sh7ffff, 16'sd0, 16'sd0, 16'sd0}, 1'b1, IDENTITY},
		'{'{20'sh80000, 16'sd0, 16'sd0, 16'sd0}, 1'b1, IDENTITY},
		'{'{20'sd0, 16'sd1, 16'sd0, 16'sd0}, 1'b0, IDENTITY},
		'{'{20'sd46080, 16'sd0, 16'sd1, 16'sd0}, 1'b0, IDENTITY},
		'{'{20'sd92160, 16'sd0, 16'sd0, 16'sd1}, 1'b0, IDENTITY},
		'{'{-20'sd92160, 16'sd0, 16'sd0, 16'sh7fff}, 1'b0, IDENTITY},
		'{'{20'sd184320, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, IDENTITY},
		'{'{-20'sd184320, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, IDENTITY},
		'{'{20'sd138240, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, IDENTITY},
		'{'{-20'sd46080, 16'sh7fff, 16'sh8000, 16'sd1}, 1'b0, IDENTITY},
		'{'{20'sh7ffff, 16'shffff, 16'shffff, 16'shffff}, 1'b0, IDENTITY},
		'{'{20'sh80000, 16'sd3, 16'sd4, 16'sd0}, 1'b0, IDENTITY},
		'{'{20'sd92161, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, IDENTITY},
		'{'{-20'sd92161, 16'sd1, 16'sd1, 16'sd1}, 1'b0, IDENTITY},
		'{'{20'sd46081, 16'sd100, 16'sd0, 16'sd0}, 1'b0, IDENTITY},
		'{'{20'sd1, 16'sd0, 16'sd0, 16'shffff}, 1'b0, IDENTITY}
	};

	task automatic send_beat(in_beat_t b, bit known = 1'b0, out_beat_t want = '0);
		rot.data  <= b;
		rot.valid <= 1'b1;
		do @(posedge clk); while (!rot.ready);
		quat_expected.push_back(known ? want : rotation_quat(b));
		@(negedge clk);
	endtask

	task automatic idle_sender();
		int g = gap_len();
		if (g > 0) begin
			rot.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic in_beat_t random_rotation();
		in_beat_t b;
		int p = $urandom_range(0, 99);
		b.angle_deg = 20'($urandom);
		b.axis_x = 16'($urandom); b.axis_y = 16'($urandom); b.axis_z = 16'($urandom);
		if (p < 10) begin
			b.axis_x = '0; b.axis_y = '0; b.axis_z = '0;
		end else if (p < 35) begin
			// short axes and near-quadrant angles exercise rounding and folding
			b.axis_x = $signed(4'($urandom));
			b.axis_y = $signed(4'($urandom));
			b.axis_z = $signed(4'($urandom));
			b.angle_deg = 20'(QUARTER_TURN * $urandom_range(0, 11)
				- 6 * QUARTER_TURN + $signed($urandom_range(0, 4)) - 2);
		end
		return b;
	endfunction

	initial begin
		rot.valid = 1'b0;
		rot.data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			send_beat(rows[i].beat, rows[i].known, rows[i].result);
			if (i % 4 == 3) idle_sender();
		end
		for (int n = 0; n < 500; n++) begin
			if (n == 200) hold_off = 1'b1;
			send_beat(random_rotation());
			if (n > 200 && n < 300) continue;
			idle_sender();
		end
		rot.valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// output side: random stalls plus one long hold-off while input keeps coming
	initial begin
		int g;
		quat.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				quat.ready <= 1'b0;
				repeat (200) @(negedge clk);
			end
			g = gap_len();
			if (g > 0 && $urandom_range(0, 3) == 0) begin
				quat.ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			quat.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && quat.valid && quat.ready) begin
			out_beat_t want, got;
			got = quat.data;
			if (quat_expected.size() == 0) begin
				$error("result beat with nothing pending");
				mismatches++;
			end else begin
				want = quat_expected.pop_front();
				if (got.quat_x !== want.quat_x) begin
					$error("quat_x exp %0d got %0d", want.quat_x, got.quat_x); mismatches++;
				end
				if (got.quat_y !== want.quat_y) begin
					$error("quat_y exp %0d got %0d", want.quat_y, got.quat_y); mismatches++;
				end
				if (got.quat_z !== want.quat_z) begin
					$error("quat_z exp %0d got %0d", want.quat_z, got.quat_z); mismatches++;
				end
				if (got.quat_w !== want.quat_w) begin
					$error("quat_w exp %0d got %0d", want.quat_w, got.quat_w); mismatches++;
				end
				if (got.conj_x !== want.conj_x) begin
					$error("conj_x exp %0d got %0d", want.conj_x, got.conj_x); mismatches++;
				end
				if (got.conj_y !== want.conj_y) begin
					$error("conj_y exp %0d got %0d", want.conj_y, got.conj_y); mismatches++;
				end
				if (got.conj_z !== want.conj_z) begin
					$error("conj_z exp %0d got %0d", want.conj_z, got.conj_z); mismatches++;
				end
				if (got.zero_axis !== want.zero_axis) begin
					$error("zero_axis exp %0b got %0b", want.zero_axis, got.zero_axis);
					mismatches++;
				end
			end
		end
	end

	initial begin
		wait (stimulus_done);
		wait (quat_expected.size() == 0);
		repeat (LATENCY * 2) @(posedge clk);
		if (mismatches == 0 && quat_expected.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[files.f]
rtl/a2q_pkg.sv
rtl/a2q_stream_if.sv
rtl/a2q_front.sv
rtl/a2q_cell.sv
rtl/a2q_div_cell.sv
rtl/axis_angle_to_quaternion.sv
test/tb.sv
